>>> rtl/rv2m_pkg.sv
package rv2m_pkg;

  typedef logic signed [31:0] s32_t;
  typedef logic signed [33:0] s34_t;
  typedef logic signed [34:0] s35_t;

  localparam int unsigned SQRT_STEPS = 32;
  localparam int unsigned DIV_STEPS  = 31;

  localparam logic [28:0] THR_RESET = 29'd2684;

  localparam logic signed [31:0] ONE_Q30     = 32'sd1073741824;
  localparam logic [32:0]        TWO_PI_Q30  = 33'd6746518852;
  localparam s35_t               PI_S        = 35'sd3373259426;
  localparam s35_t               HALF_PI_S   = 35'sd1686629713;
  localparam s35_t               TWO_PI_S    = 35'sd6746518852;
  localparam s35_t               UPPER_FOLD  = 35'sd5059889139;
  localparam s34_t               CORDIC_GAIN = 34'sh026DD3B6A;

  // atan(2^-i) in Q.30
  function automatic logic [31:0] atan_q30(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'h3243F6A8;
      5'd1:  v = 32'h1DAC6705;
      5'd2:  v = 32'h0FADBAFC;
      5'd3:  v = 32'h07F56EA6;
      5'd4:  v = 32'h03FEAB76;
      5'd5:  v = 32'h01FFD55B;
      5'd6:  v = 32'h00FFFAAA;
      5'd7:  v = 32'h007FFF55;
      5'd8:  v = 32'h003FFFEA;
      5'd9:  v = 32'h001FFFFD;
      5'd10: v = 32'h000FFFFF;
      5'd11: v = 32'h0007FFFF;
      5'd12: v = 32'h0003FFFF;
      5'd13: v = 32'h0001FFFF;
      5'd14: v = 32'h0000FFFF;
      5'd15: v = 32'h00007FFF;
      5'd16: v = 32'h00003FFF;
      5'd17: v = 32'h00001FFF;
      5'd18: v = 32'h00000FFF;
      5'd19: v = 32'h000007FF;
      5'd20: v = 32'h000003FF;
      5'd21: v = 32'h000001FF;
      5'd22: v = 32'h000000FF;
      5'd23: v = 32'h0000007F;
      5'd24: v = 32'h0000003F;
      5'd25: v = 32'h0000001F;
      5'd26: v = 32'h0000000F;
      5'd27: v = 32'h00000008;
      5'd28: v = 32'h00000004;
      5'd29: v = 32'h00000002;
      5'd30: v = 32'h00000001;
      default: v = 32'h00000000;
    endcase
    return v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [36:0] v);
    logic [31:0] r;
    if (v > 37'sd2147483647) begin
      r = 32'h7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      r = 32'h80000000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/rotation_vector_to_matrix.sv
// Rotation vector (Q3.28 by default, angle times unit axis) to 3x3 rotation
// matrix in Q1.30 by Rodrigues' formula. One request is taken every cycle
// while no result waits in the output register. The pipeline has a square
// stage and a sum stage, 32 square-root cells, a setup register, 31 divide
// cells (three quotients each, the angle modulo 2*pi rides in the first
// 31 - FRAC_BITS of them), a fold register, CORDIC_STEPS rotation cells,
// product stages A, B and C and the output register. The whole chain holds
// while a result waits in the output register. Lengths below the threshold
// register (and a zero vector) give the identity with tiny_angle_o set.
module rotation_vector_to_matrix #(
  parameter int unsigned CORDIC_STEPS = 28,
  parameter int unsigned FRAC_BITS    = 28
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [28:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] rot_x_i,
  input  logic signed [31:0] rot_y_i,
  input  logic signed [31:0] rot_z_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] m00_o,
  output logic signed [31:0] m01_o,
  output logic signed [31:0] m02_o,
  output logic signed [31:0] m10_o,
  output logic signed [31:0] m11_o,
  output logic signed [31:0] m12_o,
  output logic signed [31:0] m20_o,
  output logic signed [31:0] m21_o,
  output logic signed [31:0] m22_o,
  output logic               tiny_angle_o
);

  localparam int unsigned SQ_N      = rv2m_pkg::SQRT_STEPS;
  localparam int unsigned DV_N      = rv2m_pkg::DIV_STEPS;
  localparam int unsigned ANG_W     = 63 - FRAC_BITS;
  localparam int unsigned RED_STEPS = 31 - FRAC_BITS;

  logic en;
  logic [28:0] thr_q;

  // threshold register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= rv2m_pkg::THR_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      thr_q <= cfg_wdata_i;
    end
  end
  assign cfg_ready_o = 1'b1;

  logic out_valid_q;
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // stage 1: squares
  rv2m_pkg::s32_t r_in [3];
  logic [31:0]    mag_in [3];
  logic           s1_v_q;
  logic [63:0]    s1_sq_q [3];
  rv2m_pkg::s32_t s1_r_q [3];

  always_comb begin
    r_in[0] = rot_x_i;
    r_in[1] = rot_y_i;
    r_in[2] = rot_z_i;
    for (int k = 0; k < 3; k++) begin
      mag_in[k] = r_in[k][31] ? $unsigned(-r_in[k]) : $unsigned(r_in[k]);
    end
  end

  // stage 2: sum of squares
  logic           s2_v_q;
  logic [63:0]    s2_sum_q;
  rv2m_pkg::s32_t s2_r_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i && in_ready_o;
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        s1_sq_q[k] <= mag_in[k] * mag_in[k];
      end
      s1_r_q   <= r_in;
      s2_sum_q <= s1_sq_q[0] + s1_sq_q[1] + s1_sq_q[2];
      s2_r_q   <= s1_r_q;
    end
  end

  // square root cells
  logic [SQ_N:0]  sq_v;
  logic [63:0]    sq_rem  [SQ_N+1];
  logic [63:0]    sq_root [SQ_N+1];
  rv2m_pkg::s32_t sq_r    [SQ_N+1][3];

  assign sq_v[0]    = s2_v_q;
  assign sq_rem[0]  = s2_sum_q;
  assign sq_root[0] = '0;
  assign sq_r[0]    = s2_r_q;

  for (genvar i = 0; i < SQ_N; i++) begin : g_sqrt
    rv2m_sqrt_cell #(.STEP(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (sq_v[i]),
      .rem_i   (sq_rem[i]),
      .root_i  (sq_root[i]),
      .r_i     (sq_r[i]),
      .valid_o (sq_v[i+1]),
      .rem_o   (sq_rem[i+1]),
      .root_o  (sq_root[i+1]),
      .r_o     (sq_r[i+1])
    );
  end

  // setup: threshold test, dividends, angle in Q.30
  logic [31:0]      len;
  logic [31:0]      pmag [3];
  logic             p_v_q, p_tiny_q;
  logic [31:0]      p_len_q;
  logic [2:0]       p_neg_q;
  logic [61:0]      p_rem_q [3];
  logic [ANG_W-1:0] p_ang_q;
  logic [30:0]      zero_quo [3];

  always_comb begin
    len = sq_root[SQ_N][31:0];
    for (int k = 0; k < 3; k++) begin
      pmag[k] = sq_r[SQ_N][k][31] ? $unsigned(-sq_r[SQ_N][k]) : $unsigned(sq_r[SQ_N][k]);
      zero_quo[k] = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
    end else if (en) begin
      p_v_q <= sq_v[SQ_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      p_len_q  <= len;
      p_tiny_q <= (len == 32'd0) || (len < {3'b000, thr_q});
      for (int k = 0; k < 3; k++) begin
        p_neg_q[k] <= sq_r[SQ_N][k][31];
        p_rem_q[k] <= {pmag[k], 30'b0};
      end
      p_ang_q <= ANG_W'(len) << (30 - FRAC_BITS);
    end
  end

  // divide cells, angle reduction alongside
  logic [DV_N:0]    dv_v;
  logic [31:0]      dv_len  [DV_N+1];
  logic [2:0]       dv_neg  [DV_N+1];
  logic [DV_N:0]    dv_tiny;
  logic [61:0]      dv_rem  [DV_N+1][3];
  logic [30:0]      dv_quo  [DV_N+1][3];
  logic [ANG_W-1:0] dv_ang  [DV_N+1];

  assign dv_v[0]    = p_v_q;
  assign dv_len[0]  = p_len_q;
  assign dv_neg[0]  = p_neg_q;
  assign dv_tiny[0] = p_tiny_q;
  assign dv_rem[0]  = p_rem_q;
  assign dv_quo[0]  = zero_quo;
  assign dv_ang[0]  = p_ang_q;

  for (genvar i = 0; i < DV_N; i++) begin : g_div
    rv2m_div_cell #(
      .STEP      (i),
      .ANG_W     (ANG_W),
      .RED_STEPS (RED_STEPS)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (dv_v[i]),
      .len_i   (dv_len[i]),
      .neg_i   (dv_neg[i]),
      .tiny_i  (dv_tiny[i]),
      .rem_i   (dv_rem[i]),
      .quo_i   (dv_quo[i]),
      .ang_i   (dv_ang[i]),
      .valid_o (dv_v[i+1]),
      .len_o   (dv_len[i+1]),
      .neg_o   (dv_neg[i+1]),
      .tiny_o  (dv_tiny[i+1]),
      .rem_o   (dv_rem[i+1]),
      .quo_o   (dv_quo[i+1]),
      .ang_o   (dv_ang[i+1])
    );
  end

  // fold the angle into [-pi/2, pi/2], sign the axis
  rv2m_pkg::s35_t red_s, z_fold;
  logic           negc_fold;
  rv2m_pkg::s32_t u_fold [3];
  logic           f_v_q, f_tiny_q, f_negc_q;
  rv2m_pkg::s34_t f_z_q;
  rv2m_pkg::s32_t f_u_q [3];

  always_comb begin
    red_s = $signed({2'b00, dv_ang[DV_N][32:0]});
    if (red_s <= rv2m_pkg::HALF_PI_S) begin
      z_fold    = red_s;
      negc_fold = 1'b0;
    end else if (red_s < rv2m_pkg::UPPER_FOLD) begin
      z_fold    = rv2m_pkg::PI_S - red_s;
      negc_fold = 1'b1;
    end else begin
      z_fold    = red_s - rv2m_pkg::TWO_PI_S;
      negc_fold = 1'b0;
    end
    for (int k = 0; k < 3; k++) begin
      u_fold[k] = dv_neg[DV_N][k] ? -$signed({1'b0, dv_quo[DV_N][k]})
                                  : $signed({1'b0, dv_quo[DV_N][k]});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f_v_q <= 1'b0;
    end else if (en) begin
      f_v_q <= dv_v[DV_N];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      f_z_q    <= 34'(z_fold);
      f_negc_q <= negc_fold;
      f_tiny_q <= dv_tiny[DV_N];
      f_u_q    <= u_fold;
    end
  end

  // CORDIC cells
  logic [CORDIC_STEPS:0] cd_v, cd_tiny, cd_negc;
  rv2m_pkg::s34_t        cd_x [CORDIC_STEPS+1];
  rv2m_pkg::s34_t        cd_y [CORDIC_STEPS+1];
  rv2m_pkg::s34_t        cd_z [CORDIC_STEPS+1];
  rv2m_pkg::s32_t        cd_u [CORDIC_STEPS+1][3];

  assign cd_v[0]    = f_v_q;
  assign cd_tiny[0] = f_tiny_q;
  assign cd_negc[0] = f_negc_q;
  assign cd_x[0]    = rv2m_pkg::CORDIC_GAIN;
  assign cd_y[0]    = '0;
  assign cd_z[0]    = f_z_q;
  assign cd_u[0]    = f_u_q;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    rv2m_cordic_cell #(.STEP(i)) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .en_i    (en),
      .valid_i (cd_v[i]),
      .x_i     (cd_x[i]),
      .y_i     (cd_y[i]),
      .z_i     (cd_z[i]),
      .u_i     (cd_u[i]),
      .tiny_i  (cd_tiny[i]),
      .negc_i  (cd_negc[i]),
      .valid_o (cd_v[i+1]),
      .x_o     (cd_x[i+1]),
      .y_o     (cd_y[i+1]),
      .z_o     (cd_z[i+1]),
      .u_o     (cd_u[i+1]),
      .tiny_o  (cd_tiny[i+1]),
      .negc_o  (cd_negc[i+1])
    );
  end

  logic        mx_v, mx_tiny;
  logic [31:0] mx_m [9];

  rv2m_matrix u_matrix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (cd_v[CORDIC_STEPS]),
    .x_i     (cd_x[CORDIC_STEPS]),
    .y_i     (cd_y[CORDIC_STEPS]),
    .u_i     (cd_u[CORDIC_STEPS]),
    .tiny_i  (cd_tiny[CORDIC_STEPS]),
    .negc_i  (cd_negc[CORDIC_STEPS]),
    .valid_o (mx_v),
    .tiny_o  (mx_tiny),
    .m_o     (mx_m)
  );

  // output register, identity for tiny angles
  logic [31:0] m_q [9];
  logic        tiny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= mx_v;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      tiny_q <= mx_tiny;
      for (int k = 0; k < 9; k++) begin
        if (mx_tiny) begin
          m_q[k] <= (k % 4 == 0) ? rv2m_pkg::ONE_Q30 : 32'd0;
        end else begin
          m_q[k] <= mx_m[k];
        end
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign tiny_angle_o = tiny_q;
  assign m00_o = m_q[0];
  assign m01_o = m_q[1];
  assign m02_o = m_q[2];
  assign m10_o = m_q[3];
  assign m11_o = m_q[4];
  assign m12_o = m_q[5];
  assign m20_o = m_q[6];
  assign m21_o = m_q[7];
  assign m22_o = m_q[8];

  // square root leaves a remainder of at most twice the root
  a_sqrt_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sq_v[SQ_N] |-> (sq_root[SQ_N][63:32] == 32'd0) &&
                   (sq_rem[SQ_N] <= {sq_root[SQ_N][62:0], 1'b0}))
    else $error("square root remainder out of range");

  // axis quotients stay within one and remainders below the divisor
  a_div_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_v[DV_N] && !dv_tiny[DV_N] |->
      (dv_quo[DV_N][0] <= 31'h40000000) && (dv_quo[DV_N][1] <= 31'h40000000) &&
      (dv_quo[DV_N][2] <= 31'h40000000) &&
      (dv_rem[DV_N][0] < 62'(dv_len[DV_N])) && (dv_rem[DV_N][1] < 62'(dv_len[DV_N])) &&
      (dv_rem[DV_N][2] < 62'(dv_len[DV_N])))
    else $error("divider result out of range");

  a_tiny_identity: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && tiny_angle_o |->
      (m00_o == rv2m_pkg::ONE_Q30) && (m11_o == rv2m_pkg::ONE_Q30) &&
      (m22_o == rv2m_pkg::ONE_Q30) && (m01_o == 32'sd0) && (m12_o == 32'sd0) &&
      (m20_o == 32'sd0))
    else $error("tiny angle without identity");

  // a new request is refused only while a result waits
  a_ready_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without pending result");

endmodule

>>> rtl/rv2m_sqrt_cell.sv
module rv2m_sqrt_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [63:0]        rem_i,
  input  logic [63:0]        root_i,
  input  rv2m_pkg::s32_t     r_i [3],
  output logic               valid_o,
  output logic [63:0]        rem_o,
  output logic [63:0]        root_o,
  output rv2m_pkg::s32_t     r_o [3]
);

  localparam logic [63:0] BIT = 64'd1 << (62 - 2 * STEP);

  logic [63:0] trial;
  logic        ge;
  logic [63:0] rem_d, root_d;
  logic        valid_q;
  logic [63:0] rem_q, root_q;
  rv2m_pkg::s32_t r_q [3];

  always_comb begin
    trial  = root_i + BIT;
    ge     = rem_i >= trial;
    rem_d  = ge ? rem_i - trial : rem_i;
    root_d = ge ? (root_i >> 1) + BIT : root_i >> 1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q  <= rem_d;
      root_q <= root_d;
      r_q    <= r_i;
    end
  end

  assign valid_o = valid_q;
  assign rem_o   = rem_q;
  assign root_o  = root_q;
  assign r_o     = r_q;

endmodule

>>> rtl/rv2m_div_cell.sv
module rv2m_div_cell #(
  parameter int unsigned STEP      = 0,
  parameter int unsigned ANG_W     = 35,
  parameter int unsigned RED_STEPS = 3
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  logic [31:0]        len_i,
  input  logic [2:0]         neg_i,
  input  logic               tiny_i,
  input  logic [61:0]        rem_i [3],
  input  logic [30:0]        quo_i [3],
  input  logic [ANG_W-1:0]   ang_i,
  output logic               valid_o,
  output logic [31:0]        len_o,
  output logic [2:0]         neg_o,
  output logic               tiny_o,
  output logic [61:0]        rem_o [3],
  output logic [30:0]        quo_o [3],
  output logic [ANG_W-1:0]   ang_o
);

  localparam int unsigned J = 30 - STEP;

  logic [62:0]      dsh;
  logic [2:0]       ge;
  logic [61:0]      rem_d [3];
  logic [30:0]      quo_d [3];
  logic [ANG_W-1:0] ang_d;

  logic             valid_q;
  logic [31:0]      len_q;
  logic [2:0]       neg_q;
  logic             tiny_q;
  logic [61:0]      rem_q [3];
  logic [30:0]      quo_q [3];
  logic [ANG_W-1:0] ang_q;

  always_comb begin
    dsh = 63'(len_i) << J;
    for (int k = 0; k < 3; k++) begin
      ge[k]    = {1'b0, rem_i[k]} >= dsh;
      rem_d[k] = ge[k] ? rem_i[k] - dsh[61:0] : rem_i[k];
      quo_d[k] = quo_i[k] | (31'(ge[k]) << J);
    end
  end

  // subtract a scaled 2*pi while the angle still needs reducing
  if (STEP < RED_STEPS) begin : g_red
    localparam logic [ANG_W-1:0] SUB =
      ANG_W'(rv2m_pkg::TWO_PI_Q30) << (RED_STEPS - 1 - STEP);
    assign ang_d = (ang_i >= SUB) ? ang_i - SUB : ang_i;
  end else begin : g_hold
    assign ang_d = ang_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      len_q  <= len_i;
      neg_q  <= neg_i;
      tiny_q <= tiny_i;
      rem_q  <= rem_d;
      quo_q  <= quo_d;
      ang_q  <= ang_d;
    end
  end

  assign valid_o = valid_q;
  assign len_o   = len_q;
  assign neg_o   = neg_q;
  assign tiny_o  = tiny_q;
  assign rem_o   = rem_q;
  assign quo_o   = quo_q;
  assign ang_o   = ang_q;

endmodule

>>> rtl/rv2m_cordic_cell.sv
module rv2m_cordic_cell #(
  parameter int unsigned STEP = 0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rv2m_pkg::s34_t     x_i,
  input  rv2m_pkg::s34_t     y_i,
  input  rv2m_pkg::s34_t     z_i,
  input  rv2m_pkg::s32_t     u_i [3],
  input  logic               tiny_i,
  input  logic               negc_i,
  output logic               valid_o,
  output rv2m_pkg::s34_t     x_o,
  output rv2m_pkg::s34_t     y_o,
  output rv2m_pkg::s34_t     z_o,
  output rv2m_pkg::s32_t     u_o [3],
  output logic               tiny_o,
  output logic               negc_o
);

  localparam rv2m_pkg::s34_t AT = 34'(rv2m_pkg::atan_q30(5'(STEP)));

  rv2m_pkg::s34_t dx, dy, x_d, y_d, z_d;
  logic           valid_q, tiny_q, negc_q;
  rv2m_pkg::s34_t x_q, y_q, z_q;
  rv2m_pkg::s32_t u_q [3];

  always_comb begin
    dx = y_i >>> STEP;
    dy = x_i >>> STEP;
    if (!z_i[33]) begin
      x_d = x_i - dx;
      y_d = y_i + dy;
      z_d = z_i - AT;
    end else begin
      x_d = x_i + dx;
      y_d = y_i - dy;
      z_d = z_i + AT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_q    <= x_d;
      y_q    <= y_d;
      z_q    <= z_d;
      u_q    <= u_i;
      tiny_q <= tiny_i;
      negc_q <= negc_i;
    end
  end

  assign valid_o = valid_q;
  assign x_o     = x_q;
  assign y_o     = y_q;
  assign z_o     = z_q;
  assign u_o     = u_q;
  assign tiny_o  = tiny_q;
  assign negc_o  = negc_q;

endmodule

>>> rtl/rv2m_matrix.sv
module rv2m_matrix (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  rv2m_pkg::s34_t     x_i,
  input  rv2m_pkg::s34_t     y_i,
  input  rv2m_pkg::s32_t     u_i [3],
  input  logic               tiny_i,
  input  logic               negc_i,
  output logic               valid_o,
  output logic               tiny_o,
  output logic [31:0]        m_o [9]
);

  typedef logic signed [32:0] s33_t;
  typedef logic signed [35:0] s36_t;

  // stage A: products with the axis
  logic signed [63:0] uu [6];
  logic signed [65:0] su [3];
  logic signed [65:0] nsu [3];
  rv2m_pkg::s35_t     c_a, omc_a;

  logic               a_v_q, a_tiny_q;
  rv2m_pkg::s32_t     a_sq_q [3];
  rv2m_pkg::s32_t     a_p_q [3];
  s33_t               a_sp_q [3];
  s33_t               a_sn_q [3];
  rv2m_pkg::s35_t     a_omc_q;

  always_comb begin
    uu[0] = u_i[0] * u_i[0];
    uu[1] = u_i[1] * u_i[1];
    uu[2] = u_i[2] * u_i[2];
    uu[3] = u_i[0] * u_i[1];
    uu[4] = u_i[0] * u_i[2];
    uu[5] = u_i[1] * u_i[2];
    for (int k = 0; k < 3; k++) begin
      su[k]  = y_i * u_i[k];
      nsu[k] = -su[k];
    end
    c_a   = negc_i ? -35'(x_i) : 35'(x_i);
    omc_a = 35'(rv2m_pkg::ONE_Q30) - c_a;
  end

  // stage B: negated sums of squares
  logic               b_v_q, b_tiny_q;
  s33_t               b_ns_q [3];
  rv2m_pkg::s32_t     b_p_q [3];
  s33_t               b_sp_q [3];
  s33_t               b_sn_q [3];
  rv2m_pkg::s35_t     b_omc_q;

  // stage C: products with 1 - cos
  logic signed [67:0] od_full [3];
  logic signed [66:0] op_full [3];
  logic               c_v_q, c_tiny_q;
  s36_t               c_od_q [3];
  s36_t               c_op_q [3];
  s33_t               c_sp_q [3];
  s33_t               c_sn_q [3];

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      od_full[k] = b_omc_q * b_ns_q[k];
      op_full[k] = b_omc_q * b_p_q[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
    end else if (en_i) begin
      a_v_q <= valid_i;
      b_v_q <= a_v_q;
      c_v_q <= b_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_tiny_q <= tiny_i;
      a_omc_q  <= omc_a;
      for (int k = 0; k < 3; k++) begin
        a_sq_q[k] <= uu[k][61:30];
        a_p_q[k]  <= uu[k+3][61:30];
        a_sp_q[k] <= su[k][62:30];
        a_sn_q[k] <= nsu[k][62:30];
      end
      b_tiny_q  <= a_tiny_q;
      b_omc_q   <= a_omc_q;
      b_ns_q[0] <= -(33'(a_sq_q[1]) + 33'(a_sq_q[2]));
      b_ns_q[1] <= -(33'(a_sq_q[0]) + 33'(a_sq_q[2]));
      b_ns_q[2] <= -(33'(a_sq_q[0]) + 33'(a_sq_q[1]));
      b_p_q     <= a_p_q;
      b_sp_q    <= a_sp_q;
      b_sn_q    <= a_sn_q;
      c_tiny_q  <= b_tiny_q;
      for (int k = 0; k < 3; k++) begin
        c_od_q[k] <= od_full[k][65:30];
        c_op_q[k] <= op_full[k][65:30];
      end
      c_sp_q <= b_sp_q;
      c_sn_q <= b_sn_q;
    end
  end

  // p index: 0 -> u0u1, 1 -> u0u2, 2 -> u1u2
  always_comb begin
    m_o[0] = rv2m_pkg::sat32(37'(rv2m_pkg::ONE_Q30) + 37'(c_od_q[0]));
    m_o[1] = rv2m_pkg::sat32(37'(c_sn_q[2]) + 37'(c_op_q[0]));
    m_o[2] = rv2m_pkg::sat32(37'(c_sp_q[1]) + 37'(c_op_q[1]));
    m_o[3] = rv2m_pkg::sat32(37'(c_sp_q[2]) + 37'(c_op_q[0]));
    m_o[4] = rv2m_pkg::sat32(37'(rv2m_pkg::ONE_Q30) + 37'(c_od_q[1]));
    m_o[5] = rv2m_pkg::sat32(37'(c_sn_q[0]) + 37'(c_op_q[2]));
    m_o[6] = rv2m_pkg::sat32(37'(c_sn_q[1]) + 37'(c_op_q[1]));
    m_o[7] = rv2m_pkg::sat32(37'(c_sp_q[0]) + 37'(c_op_q[2]));
    m_o[8] = rv2m_pkg::sat32(37'(rv2m_pkg::ONE_Q30) + 37'(c_od_q[2]));
  end

  assign valid_o = c_v_q;
  assign tiny_o  = c_tiny_q;

endmodule

>>> bench/rotation_vector_to_matrix_tb.sv
`timescale 1ns / 100ps

module rotation_vector_to_matrix_tb;

  localparam int LATENCY = 99;
  localparam longint ONE = 64'sd1073741824;
  localparam longint PI_Q30 = 64'sd3373259426;
  localparam longint HPI_Q30 = 64'sd1686629713;
  localparam longint TWO_PI_Q30 = 64'sd6746518852;

  typedef struct {
    logic signed [31:0] m [9];
    logic tiny;
  } matrix_t;

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_valid_i = 0;
  logic cfg_ready_o;
  logic [28:0] cfg_wdata_i = '0;
  logic in_valid_i = 0;
  logic in_ready_o;
  logic signed [31:0] rot_x_i = '0, rot_y_i = '0, rot_z_i = '0;
  logic out_valid_o;
  logic out_ready_i = 0;
  logic signed [31:0] m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o;
  logic tiny_angle_o;

  rotation_vector_to_matrix uut (.*);

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  longint thr = 2684;
  matrix_t expected_q[$];
  int errors = 0;
  int n_sent = 0, n_got = 0, n_tiny = 0;
  bit hold_off = 0;
  bit rx_stall_en = 1;

  function automatic longint asr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint mulq(longint a, longint b);
    return (a * b) >>> 30;
  endfunction

  function automatic longint unsigned root64(longint unsigned x);
    longint unsigned r = 0, b = 64'd1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic logic signed [31:0] clip(longint v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic matrix_t rodrigues(logic signed [31:0] rx, ry, rz);
    matrix_t res;
    longint r [3];
    longint u [3];
    longint sq [3];
    longint mm [9];
    longint unsigned sum, len, mag;
    longint t, x, y, z, dx, dy, s, c, omc;
    bit flip;
    r[0] = rx; r[1] = ry; r[2] = rz;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag = r[i] < 0 ? -r[i] : r[i];
      sum += mag * mag;
    end
    len = root64(sum);
    if (len == 0 || len < thr) begin
      for (int i = 0; i < 9; i++) res.m[i] = (i % 4 == 0) ? ONE[31:0] : '0;
      res.tiny = 1;
      return res;
    end
    for (int i = 0; i < 3; i++) begin
      mag = r[i] < 0 ? -r[i] : r[i];
      u[i] = longint'((mag << 30) / len);
      if (r[i] < 0) u[i] = -u[i];
    end
    t = longint'((len << 2) % longint'(TWO_PI_Q30));
    if (t > PI_Q30) t -= TWO_PI_Q30;
    flip = 0;
    if (t > HPI_Q30) begin
      t = PI_Q30 - t; flip = 1;
    end else if (t < -HPI_Q30) begin
      t = -PI_Q30 - t; flip = 1;
    end
    x = 64'h26DD3B6A; y = 0; z = t;
    for (int i = 0; i < 28; i++) begin
      dx = asr(y, i); dy = asr(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= longint'(rv2m_pkg::atan_q30(i[4:0]));
      end else begin
        x += dx; y -= dy; z += longint'(rv2m_pkg::atan_q30(i[4:0]));
      end
    end
    s = y;
    c = flip ? -x : x;
    omc = ONE - c;
    for (int i = 0; i < 3; i++) sq[i] = mulq(u[i], u[i]);
    mm[0] = ONE + mulq(omc, -(sq[1] + sq[2]));
    mm[4] = ONE + mulq(omc, -(sq[0] + sq[2]));
    mm[8] = ONE + mulq(omc, -(sq[0] + sq[1]));
    mm[1] = mulq(s, -u[2]) + mulq(omc, mulq(u[0], u[1]));
    mm[2] = mulq(s, u[1]) + mulq(omc, mulq(u[0], u[2]));
    mm[3] = mulq(s, u[2]) + mulq(omc, mulq(u[1], u[0]));
    mm[5] = mulq(s, -u[0]) + mulq(omc, mulq(u[1], u[2]));
    mm[6] = mulq(s, -u[1]) + mulq(omc, mulq(u[2], u[0]));
    mm[7] = mulq(s, u[0]) + mulq(omc, mulq(u[2], u[1]));
    for (int i = 0; i < 9; i++) res.m[i] = clip(mm[i]);
    res.tiny = 0;
    return res;
  endfunction

  function automatic int gap_len();
    int p = $urandom_range(0, 99);
    if (p < 45) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // valid stays high across back-to-back requests; drop it only for a gap
  task automatic send_vector(logic signed [31:0] x, y, z);
    int g = gap_len();
    if (g > 0) begin
      in_valid_i <= 0;
      repeat (g) @(posedge clk_i);
    end
    in_valid_i <= 1;
    rot_x_i <= x; rot_y_i <= y; rot_z_i <= z;
    expected_q.push_back(rodrigues(x, y, z));
    n_sent++;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic drain();
    int guard = 0;
    in_valid_i <= 0;
    while (expected_q.size() != 0 && guard < 200000) begin
      @(posedge clk_i);
      guard++;
    end
    // results past the pipe tail may still be in flight
    repeat (LATENCY + 10) @(posedge clk_i);
  endtask

  task automatic write_threshold(logic [28:0] v);
    drain();
    cfg_valid_i <= 1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 0;
    thr = v;
  endtask

  function automatic logic signed [31:0] rnd32();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return $signed($urandom_range(0, 2000)) - 1000;
      2: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
      default: return $signed($urandom_range(0, 32'h6000_0000)) - 32'sh3000_0000;
    endcase
  endfunction

  task automatic test_directed();
    send_vector(0, 0, 0);
    send_vector(1, 0, 0);
    send_vector(2683, 0, 0);
    send_vector(0, 2684, 0);
    send_vector(0, 0, -2685);
    send_vector(32'sh7FFFFFFF, 0, 0);
    send_vector(32'sh80000000, 0, 0);
    send_vector(32'sh80000000, 32'sh80000000, 32'sh80000000);
    send_vector(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF);
    send_vector(0, 32'sd421657428, 0);
    send_vector(0, 0, 32'sd843314857);
    send_vector(-32'sd843314857, 0, 0);
    send_vector(32'sd268435456, 32'sd268435456, -32'sd268435456);
    send_vector(32'sd1686629713, 0, 0);
    send_vector(-1, -1, -1);
    send_vector(32'sh5555_5555, 32'shAAAA_AAAA, 32'sh0F0F_0F0F);
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_vector(rnd32(), rnd32(), rnd32());
  endtask

  task automatic test_thresholds();
    write_threshold(29'd0);
    send_vector(0, 0, 0);
    send_vector(1, 0, 0);
    test_random(40);
    write_threshold(29'h1FFF_FFFF);
    send_vector(32'sh1FFF_FFFF, 0, 0);
    send_vector(32'sh2000_0000, 0, 0);
    test_random(60);
    write_threshold(29'd268435456);
    send_vector(32'sd268435455, 0, 0);
    send_vector(0, 0, 32'sd268435456);
    test_random(60);
    write_threshold(29'd2684);
  endtask

  task automatic test_backpressure();
    drain();
    rx_stall_en = 0;
    hold_off = 1;
    fork
      begin
        repeat (300) @(posedge clk_i);
        hold_off = 0;
      end
      begin
        test_random(150);
        drain();
      end
    join
    rx_stall_en = 1;
  endtask

  // accept results, with random stalls while rx_stall_en is set
  always @(posedge clk_i) begin
    if (!rst_ni || hold_off) begin
      out_ready_i <= 0;
    end else if (rx_stall_en && $urandom_range(0, 99) < 30) begin
      out_ready_i <= 0;
    end else begin
      out_ready_i <= 1;
    end
  end

  always @(posedge clk_i) begin
    matrix_t e;
    logic signed [31:0] got [9];
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{m00_o, m01_o, m02_o, m10_o, m11_o, m12_o, m20_o, m21_o, m22_o};
      n_got++;
      if (expected_q.size() == 0) begin
        $error("unexpected result");
        errors++;
      end else begin
        e = expected_q.pop_front();
        for (int i = 0; i < 9; i++) begin
          if (got[i] !== e.m[i]) begin
            $error("m%0d%0d expected %0d got %0d", i / 3, i % 3, e.m[i], got[i]);
            errors++;
          end
        end
        if (tiny_angle_o !== e.tiny) begin
          $error("tiny_angle expected %0d got %0d", e.tiny, tiny_angle_o);
          errors++;
        end
        if (e.tiny) n_tiny++;
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);
    test_directed();
    test_random(120);
    test_thresholds();
    test_backpressure();
    drain();
    $display("sent %0d vectors, checked %0d matrices (%0d identity for small angle)",
             n_sent, n_got, n_tiny);
    $display("covered threshold extremes and a long output stall");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("rotation_vector_to_matrix_tb OK");
    end else begin
      if (expected_q.size() != 0) $error("%0d results missing", expected_q.size());
      $display("rotation_vector_to_matrix_tb NOT OK");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("rotation_vector_to_matrix_tb NOT OK");
    $finish;
  end

endmodule

>>> sim.f
rtl/rv2m_pkg.sv
rtl/rv2m_sqrt_cell.sv
rtl/rv2m_div_cell.sv
rtl/rv2m_cordic_cell.sv
rtl/rv2m_matrix.sv
rtl/rotation_vector_to_matrix.sv
bench/rotation_vector_to_matrix_tb.sv
